[hdl/framebuffer_line_circle_engine_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame store drawing engine
// Concurrent checks clocked on clk and idle during rst.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_LINE_CIRCLE_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_LINE_CIRCLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define FLCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FLCE_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FLCE_ASSERT(label, prop, msg)
`define FLCE_NEVER(label, expr, msg)
`endif
`endif

[hdl/flce_pkg.sv]
// ----------------------------------------------------------------------------
// flce_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package flce_pkg;
  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;

  localparam logic [2:0] OP_LINE = 3'd0;
  localparam logic [2:0] OP_RECT = 3'd1;
  localparam logic [2:0] OP_CIRC = 3'd2;
  localparam logic [2:0] OP_FILL = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  localparam logic [1:0] SRC_END  = 2'd0;
  localparam logic [1:0] SRC_WALK = 2'd1;
  localparam logic [1:0] SRC_CIRC = 2'd2;

  localparam logic [7:0] FILL_ONES  = 8'hFF;
  localparam logic [7:0] FILL_ZEROS = 8'h00;

  typedef struct packed {
    logic       load;
    logic       seg_load;
    logic [1:0] seg;
    logic [1:0] src;
    logic       pix_wr;
    logic       line_step;
    logic       circ_step;
    logic [1:0] quad;
    logic       sweep_wr;
    logic       rd_byte;
    logic       rd_capture;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic centre_ok;
    logic circ_last;
    logic sweep_last;
  } status_t;
endpackage

[hdl/flce_ctrl.sv]
// ----------------------------------------------------------------------------
// flce_ctrl
// Operation sequencer: store sweep, pixel read-modify-write, segment and quadrant stepping, byte read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "framebuffer_line_circle_engine_assert.svh"
module flce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       operation,
  input  flce_pkg::status_t status,
  output flce_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done
);
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LSETUP = 4'd2;
  localparam logic [3:0] S_EP_RD  = 4'd3;
  localparam logic [3:0] S_EP_WR  = 4'd4;
  localparam logic [3:0] S_LCHK   = 4'd5;
  localparam logic [3:0] S_WK_RD  = 4'd6;
  localparam logic [3:0] S_WK_WR  = 4'd7;
  localparam logic [3:0] S_CCHK   = 4'd8;
  localparam logic [3:0] S_C_RD   = 4'd9;
  localparam logic [3:0] S_C_WR   = 4'd10;
  localparam logic [3:0] S_READ   = 4'd11;
  localparam logic [3:0] S_READ2  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] seg, seg_next;
  logic [1:0] quad, quad_next;
  logic       is_rect, is_rect_next;
  logic       fill_op, fill_op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      seg     <= 2'd0;
      quad    <= 2'd0;
      is_rect <= 1'b0;
      fill_op <= 1'b0;
    end else begin
      state   <= state_next;
      seg     <= seg_next;
      quad    <= quad_next;
      is_rect <= is_rect_next;
      fill_op <= fill_op_next;
    end
  end

  always_comb begin
    state_next   = state;
    seg_next     = seg;
    quad_next    = quad;
    is_rect_next = is_rect;
    fill_op_next = fill_op;
    cmd          = '0;
    cmd.seg      = seg;
    cmd.quad     = quad;
    cmd.src      = flce_pkg::SRC_END;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (status.sweep_last) begin
          state_next = fill_op ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          seg_next     = 2'd0;
          quad_next    = 2'd0;
          is_rect_next = (operation == flce_pkg::OP_RECT);
          fill_op_next = 1'b0;
          case (operation)
            flce_pkg::OP_LINE, flce_pkg::OP_RECT: state_next = S_LSETUP;
            flce_pkg::OP_CIRC: state_next = S_CCHK;
            flce_pkg::OP_FILL: begin
              fill_op_next = 1'b1;
              state_next   = S_CLEAR;
            end
            flce_pkg::OP_READ: state_next = S_READ;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_LSETUP: begin
        cmd.seg_load = 1'b1;
        state_next   = S_EP_RD;
      end
      S_EP_RD: state_next = S_EP_WR;
      S_EP_WR: begin
        cmd.pix_wr = 1'b1;
        state_next = S_LCHK;
      end
      S_LCHK: begin
        if (status.walk_done) begin
          if (is_rect && seg != 2'd3) begin
            seg_next   = seg + 2'd1;
            state_next = S_LSETUP;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_WK_RD;
        end
      end
      S_WK_RD: begin
        cmd.src    = flce_pkg::SRC_WALK;
        state_next = S_WK_WR;
      end
      S_WK_WR: begin
        cmd.src       = flce_pkg::SRC_WALK;
        cmd.pix_wr    = 1'b1;
        cmd.line_step = 1'b1;
        state_next    = S_LCHK;
      end
      S_CCHK: state_next = status.centre_ok ? S_C_RD : S_DONE;
      S_C_RD: begin
        cmd.src    = flce_pkg::SRC_CIRC;
        state_next = S_C_WR;
      end
      S_C_WR: begin
        cmd.src    = flce_pkg::SRC_CIRC;
        cmd.pix_wr = 1'b1;
        quad_next  = quad + 2'd1;
        if (quad == 2'd3) begin
          cmd.circ_step = 1'b1;
          state_next    = status.circ_last ? S_DONE : S_C_RD;
        end else begin
          state_next = S_C_RD;
        end
      end
      S_READ: begin
        cmd.rd_byte = 1'b1;
        state_next  = S_READ2;
      end
      S_READ2: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  `FLCE_ASSERT(a_done_one_cycle, done |=> !done && !busy, "result strobe held")
  `FLCE_ASSERT(a_wr_after_rd, cmd.pix_wr |-> $past(state) == S_EP_RD || $past(state) == S_WK_RD || $past(state) == S_C_RD, "pixel write without read")
  `FLCE_ASSERT(a_read_path, start && !busy && operation == flce_pkg::OP_READ |=> ##1 state == S_READ2, "read sequence broken")
  `FLCE_NEVER(a_no_overlap, cmd.sweep_wr && cmd.pix_wr, "sweep and pixel write together")
endmodule

[hdl/flce_dp.sv]
// ----------------------------------------------------------------------------
// flce_dp
// Frame store, line and circle walkers, pixel read-modify-write path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module flce_dp #(
  parameter int PANEL_WIDTH  = flce_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = flce_pkg::DEF_PANEL_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  flce_pkg::cmd_t    cmd,
  output flce_pkg::status_t status,
  input  logic              config_write,
  input  logic              invert_pixels,
  input  logic [2:0]        operation,
  input  logic [7:0]        x_start,
  input  logic [7:0]        y_start,
  input  logic [7:0]        x_end,
  input  logic [7:0]        y_end,
  input  logic [7:0]        radius,
  input  logic              draw_color,
  input  logic [9:0]        byte_address,
  output logic [7:0]        read_data
);
  localparam int STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
  localparam int AW          = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata;

  logic       invert;
  logic [7:0] xs, ys, xe, ye;
  logic       color, rect;
  logic [9:0] addr_r;
  logic [7:0] fill_byte;
  logic [AW-1:0] sweep_cnt;

  logic [7:0] lx1, ly1, wx, wy, adx, ady;
  logic       xneg, yneg;
  logic signed [11:0] err;

  logic signed [9:0]  cxr, cyr;
  logic signed [11:0] cerr;

  // segment endpoints
  logic [7:0] sx0, sy0, sx1, sy1, sdx, sdy;
  always_comb begin
    case (cmd.seg)
      2'd0: begin
        sx0 = xs; sy0 = ys; sx1 = xe; sy1 = rect ? ys : ye;
      end
      2'd1: begin
        sx0 = xe; sy0 = ys; sx1 = xe; sy1 = ye;
      end
      2'd2: begin
        sx0 = xe; sy0 = ye; sx1 = xs; sy1 = ye;
      end
      default: begin
        sx0 = xs; sy0 = ye; sx1 = xs; sy1 = ys;
      end
    endcase
    sdx = (sx1 > sx0) ? sx1 - sx0 : sx0 - sx1;
    sdy = (sy1 > sy0) ? sy1 - sy0 : sy0 - sy1;
  end

  // line step
  logic signed [12:0] e2;
  logic               step_x, step_y;
  logic signed [11:0] err_step;
  always_comb begin
    e2       = {err, 1'b0};
    step_x   = e2 > -$signed({5'b0, ady});
    step_y   = e2 < $signed({5'b0, adx});
    err_step = err - (step_x ? $signed({4'b0, ady}) : 12'sd0)
                   + (step_y ? $signed({4'b0, adx}) : 12'sd0);
  end

  // circle step
  logic signed [11:0] ce2, cerr_n, x_ext, y_ext;
  logic signed [9:0]  cx_n, cy_n;
  always_comb begin
    ce2    = cerr;
    cerr_n = cerr;
    cx_n   = cxr;
    cy_n   = cyr;
    x_ext  = {{2{cxr[9]}}, cxr};
    y_ext  = {{2{cyr[9]}}, cyr};
    if (ce2 <= y_ext) begin
      cy_n   = cyr + 10'sd1;
      cerr_n = cerr_n + {{1{cy_n[9]}}, cy_n, 1'b0} + 12'sd1;
      if (-cxr == cy_n && ce2 <= x_ext) begin
        ce2 = 12'sd0;
      end
    end
    if (ce2 > x_ext) begin
      cx_n   = cxr + 10'sd1;
      cerr_n = cerr_n + {{1{cx_n[9]}}, cx_n, 1'b0} + 12'sd1;
    end
  end

  // pixel select
  logic [9:0] cx10, cy10, qx, qy;
  logic [7:0] px, py;
  always_comb begin
    cx10 = {2'b0, xs};
    cy10 = {2'b0, ys};
    qx   = (cmd.quad == 2'd0 || cmd.quad == 2'd3) ? cx10 - cxr : cx10 + cxr;
    qy   = (cmd.quad == 2'd0 || cmd.quad == 2'd1) ? cy10 + cyr : cy10 - cyr;
    case (cmd.src)
      flce_pkg::SRC_WALK: begin
        px = wx; py = wy;
      end
      flce_pkg::SRC_CIRC: begin
        px = qx[7:0]; py = qy[7:0];
      end
      default: begin
        px = lx1; py = ly1;
      end
    endcase
  end

  logic          on_panel, color_eff, addr_ok, mem_we;
  logic [AW-1:0] pix_addr, rd_addr, wr_addr;
  logic [7:0]    mask, wr_data;
  assign on_panel  = (int'(px) < PANEL_WIDTH) && (int'(py) < PANEL_HEIGHT);
  assign pix_addr  = AW'(int'(px) + int'(py[7:3]) * PANEL_WIDTH);
  assign mask      = 8'b1 << py[2:0];
  assign color_eff = color ^ invert;
  assign addr_ok   = int'(addr_r) < STORE_BYTES;
  assign rd_addr   = cmd.rd_byte ? AW'(addr_r) : pix_addr;
  assign mem_we    = cmd.sweep_wr || (cmd.pix_wr && on_panel);
  assign wr_addr   = cmd.sweep_wr ? sweep_cnt : pix_addr;
  assign wr_data   = cmd.sweep_wr ? fill_byte : (color_eff ? (rdata | mask) : (rdata & ~mask));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert    <= 1'b0;
      sweep_cnt <= '0;
      fill_byte <= flce_pkg::FILL_ZEROS;
      read_data <= 8'd0;
    end else begin
      if (config_write) begin
        invert <= invert_pixels;
      end
      if (cmd.load) begin
        sweep_cnt <= '0;
        fill_byte <= draw_color ? flce_pkg::FILL_ONES : flce_pkg::FILL_ZEROS;
        read_data <= 8'd0;
      end else if (cmd.sweep_wr) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (cmd.rd_capture) begin
        read_data <= addr_ok ? rdata : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs     <= x_start;
      ys     <= y_start;
      xe     <= x_end;
      ye     <= y_end;
      color  <= draw_color;
      rect   <= (operation == flce_pkg::OP_RECT);
      addr_r <= byte_address;
      cxr    <= -$signed({2'b0, radius});
      cyr    <= 10'sd0;
      cerr   <= 12'sd2 - $signed({3'b0, radius, 1'b0});
    end else if (cmd.circ_step) begin
      cxr  <= cx_n;
      cyr  <= cy_n;
      cerr <= cerr_n;
    end
    if (cmd.seg_load) begin
      lx1  <= sx1;
      ly1  <= sy1;
      wx   <= sx0;
      wy   <= sy0;
      adx  <= sdx;
      ady  <= sdy;
      xneg <= !(sx0 < sx1);
      yneg <= !(sy0 < sy1);
      err  <= $signed({4'b0, sdx}) - $signed({4'b0, sdy});
    end else if (cmd.line_step) begin
      err <= err_step;
      if (step_x) begin
        wx <= xneg ? wx - 8'd1 : wx + 8'd1;
      end
      if (step_y) begin
        wy <= yneg ? wy - 8'd1 : wy + 8'd1;
      end
    end
  end

  assign status.walk_done  = (wx == lx1) && (wy == ly1);
  assign status.centre_ok  = (int'(xs) < PANEL_WIDTH) && (int'(ys) < PANEL_HEIGHT);
  assign status.circ_last  = cx_n > 10'sd0;
  assign status.sweep_last = (sweep_cnt == AW'(STORE_BYTES - 1));
endmodule

[hdl/framebuffer_line_circle_engine.sv]
// ----------------------------------------------------------------------------
// framebuffer_line_circle_engine
// Monochrome page-organised frame store with line, rectangle, circle drawing, fill and byte read.
// ----------------------------------------------------------------------------
// Usage: present a command word on operation and its operand ports and raise
// start; it is taken on a clock edge where busy is low. Exactly one result
// word follows, shown for one cycle with done high; read_data carries the
// byte for a read command and zero otherwise. The receiver cannot stall.
// The user must write invert_pixels with config_write while the engine is idle;
// the engine itself does not enforce this.
// Each pixel is a read-modify-write of its store byte; a circle step plots
// four points, one per quadrant; a fill sweeps every byte of the store.
// Reset clears the store with a sweep of one byte a cycle (1024 bytes at
// the default panel size); busy stays high until it is over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module framebuffer_line_circle_engine #(
  parameter int PANEL_WIDTH  = flce_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = flce_pkg::DEF_PANEL_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  logic [2:0] operation,
  input  logic [7:0] x_start,
  input  logic [7:0] y_start,
  input  logic [7:0] x_end,
  input  logic [7:0] y_end,
  input  logic [7:0] radius,
  input  logic       draw_color,
  input  logic [9:0] byte_address,
  output logic [7:0] read_data,
  input  logic       config_write,
  input  logic       invert_pixels
);
  flce_pkg::cmd_t    cmd;
  flce_pkg::status_t status;

  flce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  flce_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .config_write  (config_write),
    .invert_pixels (invert_pixels),
    .operation     (operation),
    .x_start       (x_start),
    .y_start       (y_start),
    .x_end         (x_end),
    .y_end         (y_end),
    .radius        (radius),
    .draw_color    (draw_color),
    .byte_address  (byte_address),
    .read_data     (read_data)
  );
endmodule

[bench/framebuffer_line_circle_engine_test.sv]
// ----------------------------------------------------------------------------
// Frame store drawing engine testbench
// Drives lines, rectangles, circles, fills, reads and unknown commands with
// random gaps. A behavioural copy of the engine predicts each result word,
// and every word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module framebuffer_line_circle_engine_test;
  localparam int PW = flce_pkg::DEF_PANEL_WIDTH;
  localparam int PH = flce_pkg::DEF_PANEL_HEIGHT;
  localparam int STORE_SIZE = PW * ((PH + 7) / 8);
  localparam int CYCLE_LIMIT = 20000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       done;
  logic [2:0] operation = flce_pkg::OP_LINE;
  logic [7:0] x_start = '0;
  logic [7:0] y_start = '0;
  logic [7:0] x_end = '0;
  logic [7:0] y_end = '0;
  logic [7:0] radius = '0;
  logic       draw_color = 1'b0;
  logic [9:0] byte_address = '0;
  logic [7:0] read_data;
  logic       config_write = 1'b0;
  logic       invert_pixels = 1'b0;

  logic [7:0] shadow_store [STORE_SIZE];
  logic       shadow_invert;
  logic [7:0] expected_bytes [$];
  int         fail_count = 0;
  int         words_sent = 0;
  int         words_checked = 0;
  int         cycle_count = 0;

  framebuffer_line_circle_engine i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .operation(operation), .x_start(x_start), .y_start(y_start),
    .x_end(x_end), .y_end(y_end), .radius(radius), .draw_color(draw_color),
    .byte_address(byte_address), .read_data(read_data),
    .config_write(config_write), .invert_pixels(invert_pixels)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL framebuffer_line_circle_engine");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected word, read_data %0h", read_data);
        fail_count++;
      end else begin
        if (read_data !== expected_bytes[0]) begin
          $error("read_data expected %0h actual %0h", expected_bytes[0], read_data);
          fail_count++;
        end
        void'(expected_bytes.pop_front());
        words_checked++;
      end
    end
  end

  function automatic void set_pixel(int px, int py, logic colour);
    int idx;
    px = px & 255;
    py = py & 255;
    if (px >= PW || py >= PH) return;
    colour = colour ^ shadow_invert;
    idx = px + (py / 8) * PW;
    if (colour) shadow_store[idx][py % 8] = 1'b1;
    else shadow_store[idx][py % 8] = 1'b0;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, logic colour);
    int dx, dy, sx, sy, err, e2, wx, wy, guard;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    wx = x0;
    wy = y0;
    err = dx - dy;
    guard = 0;
    set_pixel(x1, y1, colour);
    while ((wx != x1 || wy != y1) && guard < 1024) begin
      guard++;
      set_pixel(wx, wy, colour);
      e2 = err * 2;
      if (e2 > -dy) begin
        err -= dy;
        wx = (wx + sx) & 255;
      end
      if (e2 < dx) begin
        err += dx;
        wy = (wy + sy) & 255;
      end
    end
  endfunction

  function automatic void trace_circle(int cx, int cy, int r, logic colour);
    int cxo, cyo, err, e2;
    if (cx >= PW || cy >= PH) return;
    cxo = -r;
    cyo = 0;
    err = 2 - 2 * r;
    do begin
      set_pixel(cx - cxo, cy + cyo, colour);
      set_pixel(cx + cxo, cy + cyo, colour);
      set_pixel(cx + cxo, cy - cyo, colour);
      set_pixel(cx - cxo, cy - cyo, colour);
      e2 = err;
      if (e2 <= cyo) begin
        cyo++;
        err += cyo * 2 + 1;
        if (-cxo == cyo && e2 <= cxo) e2 = 0;
      end
      if (e2 > cxo) begin
        cxo++;
        err += cxo * 2 + 1;
      end
    end while (cxo <= 0);
  endfunction

  function automatic logic [7:0] predict_word(logic [2:0] op, int xs, int ys, int xe,
                                              int ye, int r, logic c, int addr);
    logic [7:0] data;
    data = 8'h00;
    case (op)
      flce_pkg::OP_LINE: trace_line(xs, ys, xe, ye, c);
      flce_pkg::OP_RECT: begin
        trace_line(xs, ys, xe, ys, c);
        trace_line(xe, ys, xe, ye, c);
        trace_line(xe, ye, xs, ye, c);
        trace_line(xs, ye, xs, ys, c);
      end
      flce_pkg::OP_CIRC: trace_circle(xs, ys, r, c);
      flce_pkg::OP_FILL: foreach (shadow_store[i])
        shadow_store[i] = c ? flce_pkg::FILL_ONES : flce_pkg::FILL_ZEROS;
      flce_pkg::OP_READ: if (addr < STORE_SIZE) data = shadow_store[addr];
      default: data = 8'h00;
    endcase
    return data;
  endfunction

  task automatic send_word(int op, int xs, int ys, int xe, int ye, int r, int c, int addr);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    operation <= 3'(op);
    x_start <= 8'(xs);
    y_start <= 8'(ys);
    x_end <= 8'(xe);
    y_end <= 8'(ye);
    radius <= 8'(r);
    draw_color <= 1'(c);
    byte_address <= 10'(addr);
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_bytes.push_back(predict_word(3'(op), xs & 255, ys & 255, xe & 255, ye & 255,
                                          r & 255, 1'(c), addr & 1023));
    words_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_invert(logic value);
    drain();
    config_write <= 1'b1;
    invert_pixels <= value;
    @(negedge clk);
    config_write <= 1'b0;
    shadow_invert = value;
  endtask

  task automatic read_random(int count);
    repeat (count) send_word(flce_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom_range(0, STORE_SIZE - 1));
  endtask

  task automatic test_directed;
    send_word(flce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
    send_word(flce_pkg::OP_LINE, 5, 5, 5, 5, 0, 1, 0);
    send_word(flce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 5);
    send_word(flce_pkg::OP_LINE, 0, 0, 127, 63, 0, 1, 0);
    send_word(flce_pkg::OP_LINE, 255, 255, 0, 0, 0, 1, 0);
    send_word(flce_pkg::OP_LINE, 120, 2, 3, 60, 0, 0, 0);
    send_word(flce_pkg::OP_RECT, 10, 10, 40, 30, 0, 1, 0);
    send_word(flce_pkg::OP_RECT, 250, 60, 4, 2, 0, 1, 0);
    send_word(flce_pkg::OP_CIRC, 64, 32, 0, 0, 20, 1, 0);
    send_word(flce_pkg::OP_CIRC, 0, 0, 255, 0, 255, 1, 0);
    send_word(flce_pkg::OP_CIRC, 200, 10, 0, 0, 5, 1, 0);
    send_word(flce_pkg::OP_CIRC, 127, 63, 0, 0, 0, 1, 0);
    send_word(flce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'h3ff);
    send_word(flce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'h3ff);
    send_word(3'd5, 0, 0, 0, 0, 0, 1, 0);
    send_word(3'd7, 255, 255, 255, 255, 255, 1, 10'h3ff);
    read_random(4);
    send_word(flce_pkg::OP_FILL, 0, 0, 0, 0, 0, 1, 0);
    send_word(flce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1023);
    send_word(flce_pkg::OP_FILL, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_inverted;
    write_invert(1'b1);
    send_word(flce_pkg::OP_LINE, 0, 0, 127, 0, 0, 0, 0);
    send_word(flce_pkg::OP_CIRC, 30, 30, 12, 0, 12, 1, 0);
    read_random(6);
    send_word(flce_pkg::OP_FILL, 0, 0, 0, 0, 0, 1, 0);
    send_word(flce_pkg::OP_LINE, 3, 8, 90, 50, 0, 1, 0);
    read_random(6);
    write_invert(1'b0);
  endtask

  task automatic test_random(int count);
    int kind;
    logic [7:0] r;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 75) write_invert($urandom_range(0, 1));
      if (n == count / 2) drain();
      kind = $urandom_range(0, 99);
      r = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
      if (kind < 40) read_random(1);
      else if (kind < 62) send_word(flce_pkg::OP_LINE, $urandom_range(0, 140),
                                    $urandom_range(0, 70), $urandom_range(0, 140),
                                    $urandom_range(0, 70), $urandom, $urandom, $urandom);
      else if (kind < 68) send_word(flce_pkg::OP_LINE, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom);
      else if (kind < 80) send_word(flce_pkg::OP_RECT, $urandom_range(0, 140),
                                    $urandom_range(0, 70), $urandom_range(0, 140),
                                    $urandom_range(0, 70), $urandom, $urandom, $urandom);
      else if (kind < 93) send_word(flce_pkg::OP_CIRC, $urandom_range(0, 135),
                                    $urandom_range(0, 70), $urandom, $urandom, r,
                                    $urandom, $urandom);
      else if (kind < 95) send_word(flce_pkg::OP_FILL, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom);
      else if (kind < 97) send_word($urandom_range(5, 7), $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom);
      else send_word(flce_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
    end
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_invert = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_inverted();
    test_random(580);
    drain();
    repeat (40) @(negedge clk);
    $display("Covered %0d words (%0d results checked): lines, rectangles, circles,",
             words_sent, words_checked);
    $display("fills, reads and unknown commands, with pixel inversion off and on.");
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("PASS framebuffer_line_circle_engine");
    end else begin
      $display("FAIL framebuffer_line_circle_engine");
    end
    $finish;
  end
endmodule
